// ===== hw/rtl/imuqaf_pkg.sv =====
// Shared types and constants for the IMU quaternion attitude filter.
// Holds the sequencer opcodes, state codes and fixed-point constants.
// Depends on nothing.
`timescale 1ns / 1ps

package imuqaf_pkg;

  localparam int QUAT_FRAC_BITS_DEF = 30;
  localparam int NEWTON_STEPS_DEF   = 2;

  // Gyro LSB (1/16 deg/s) to rad/s, Q40.
  localparam int RATE_TO_RAD_Q40 = 1199381129;
  localparam logic [31:0] SEED_MAGIC = 32'h5f3759df;

  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int ACC_W  = 70;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD     = 2'd2;

  localparam logic [15:0] PROP_GAIN_RST  = 16'd4096;
  localparam logic [15:0] INTEG_GAIN_RST = 16'd82;
  localparam logic [23:0] PERIOD_RST     = 24'd33554;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_ACC  = 5'b00100,
    S_NORM = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    OP_G,    // gyro rate to rad/s
    OP_S,    // accelerometer sum of squares
    OP_AH,   // unit accelerometer
    OP_HV,   // half gravity vector from the quaternion
    OP_HE,   // half error, cross product
    OP_FIA,  // integral gain times error
    OP_FIB,  // integral increment, upper part times period
    OP_FIC,  // integral increment, lower part times period
    OP_FP,   // proportional feedback
    OP_HA,   // half-angle increment, upper part
    OP_HB,   // half-angle increment, lower part
    OP_NQ,   // quaternion product terms
    OP_SQ,   // quaternion sum of squares
    OP_FIN,  // renormalised quaternion
    OP_NA,   // Newton step: z squared
    OP_NB,   // Newton step: m times z squared
    OP_NC    // Newton step: z times correction
  } op_t;

endpackage

// ===== hw/rtl/imu_quaternion_attitude_filter.sv =====
// Top level of the IMU quaternion attitude filter: stream ports, register
// port, sequencer and the one shared 34 x 34 multiplier. Uses imuqaf_pkg.
`timescale 1ns / 1ps

// Each input word is one IMU sample; the block returns one word with the
// updated attitude quaternion. All arithmetic runs through a single signed
// 34 x 34 multiplier under a sequencer; each multiply is issued in S_MUL,
// then accumulated and written back in S_ACC. A sample with a nonzero
// accelerometer takes 59 multiplies (53 with a zero integral gain) and two
// inverse square roots, one with a zero accelerometer 29 multiplies and
// one; each inverse square root adds a leading-bit search in S_NORM plus 3
// multiplies per Newton step. The input is not ready while a sample is
// being worked on; a finished word waits in the output register while the
// next sample is taken.
module imu_quaternion_attitude_filter #(
  parameter int QUAT_FRAC_BITS = imuqaf_pkg::QUAT_FRAC_BITS_DEF,
  parameter int NEWTON_STEPS   = imuqaf_pkg::NEWTON_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // rate_x, rate_y, rate_z, accel_x, accel_y, accel_z (16 bits each)
  input  logic [95:0]                       s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // quat_w, quat_x, quat_y, quat_z (32 bits each)
  output logic [127:0]                      m_tdata,
  // feedback_used
  output logic                              m_tuser,
  input  logic                              cfg_we,
  input  logic [imuqaf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [imuqaf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import imuqaf_pkg::*;

  localparam int QSHIFT = 30 - QUAT_FRAC_BITS;
  localparam int NK_W   = $clog2(NEWTON_STEPS + 1);
  localparam logic signed [ACC_W-1:0] ONE30   = 70'sd1 <<< 30;
  localparam logic signed [ACC_W-1:0] THREE30 = 70'sd3 <<< 30;
  localparam logic signed [ACC_W-1:0] HALF59  = 70'sd1 <<< 59;
  localparam logic signed [ACC_W-1:0] ONE_Q   = 70'sd1 <<< QUAT_FRAC_BITS;
  localparam logic signed [40:0] I32_MAX = 41'sd2147483647;
  localparam logic signed [40:0] I32_MIN = -41'sd2147483648;

  state_t state;
  op_t    op, ret_op;
  logic [1:0] ax, kt;
  logic [NK_W-1:0] nk;
  logic fb;

  logic [15:0] prop_gain_x2, integ_gain_x2;
  logic [23:0] sample_period;

  logic signed [15:0] rate [3];
  logic signed [15:0] accel [3];
  logic signed [39:0] g [3];
  logic signed [31:0] integ [3];
  logic signed [33:0] ah [3];
  logic signed [33:0] hv [3];
  logic signed [33:0] he [3];
  logic signed [31:0] h [3];
  logic signed [32:0] nq [4];
  logic signed [31:0] attitude [4];
  logic signed [31:0] q_c [4];
  logic signed [39:0] tmp;

  logic [63:0] xs;
  logic [4:0]  ex;
  logic [31:0] m, zr, d;
  logic [32:0] z2;

  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc, px, lin, sh, base, h_clamp, q_clamp, nb_d;
  logic [6:0] shamt;
  logic signed [40:0] isum, isat;
  logic [4:0] nqt;

  logic [31:0] seed_m, seed_bits, seed_est, seed_z;
  logic [23:0] seed_frac;

  function automatic logic [1:0] rot1(input logic [1:0] i);
    case (i)
      2'd0: rot1 = 2'd1;
      2'd1: rot1 = 2'd2;
      default: rot1 = 2'd0;
    endcase
  endfunction

  function automatic logic [1:0] rot2(input logic [1:0] i);
    case (i)
      2'd0: rot2 = 2'd2;
      2'd1: rot2 = 2'd0;
      default: rot2 = 2'd1;
    endcase
  endfunction

  // Term k of quaternion component j: {subtract, q index, h index}.
  function automatic logic [4:0] nq_term(input logic [1:0] j, input logic [1:0] k);
    case ({j, k})
      4'b0000: nq_term = {1'b1, 2'd1, 2'd0};
      4'b0001: nq_term = {1'b1, 2'd2, 2'd1};
      4'b0010: nq_term = {1'b1, 2'd3, 2'd2};
      4'b0100: nq_term = {1'b0, 2'd0, 2'd0};
      4'b0101: nq_term = {1'b0, 2'd2, 2'd2};
      4'b0110: nq_term = {1'b1, 2'd3, 2'd1};
      4'b1000: nq_term = {1'b0, 2'd0, 2'd1};
      4'b1001: nq_term = {1'b1, 2'd1, 2'd2};
      4'b1010: nq_term = {1'b0, 2'd3, 2'd0};
      4'b1100: nq_term = {1'b0, 2'd0, 2'd2};
      4'b1101: nq_term = {1'b0, 2'd1, 2'd1};
      4'b1110: nq_term = {1'b1, 2'd2, 2'd0};
      default: nq_term = 5'd0;
    endcase
  endfunction

  assign s_tready = (state == S_IDLE);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      q_c[i] = attitude[i] <<< QSHIFT;
    end
  end

  assign nqt = nq_term(ax, kt);

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      OP_G: begin
        mul_a = 34'(rate[ax]);
        mul_b = 34'(RATE_TO_RAD_Q40);
      end
      OP_S: begin
        mul_a = 34'(accel[ax]);
        mul_b = 34'(accel[ax]);
      end
      OP_AH: begin
        mul_a = 34'(accel[ax]);
        mul_b = 34'(zr);
      end
      OP_HV: begin
        case ({ax, kt[0]})
          3'b000: begin mul_a = 34'(q_c[1]); mul_b = 34'(q_c[3]); end
          3'b001: begin mul_a = 34'(q_c[0]); mul_b = 34'(q_c[2]); end
          3'b010: begin mul_a = 34'(q_c[0]); mul_b = 34'(q_c[1]); end
          3'b011: begin mul_a = 34'(q_c[2]); mul_b = 34'(q_c[3]); end
          3'b100: begin mul_a = 34'(q_c[0]); mul_b = 34'(q_c[0]); end
          default: begin mul_a = 34'(q_c[3]); mul_b = 34'(q_c[3]); end
        endcase
      end
      OP_HE: begin
        if (kt == 2'd0) begin
          mul_a = ah[rot1(ax)];
          mul_b = hv[rot2(ax)];
        end else begin
          mul_a = ah[rot2(ax)];
          mul_b = hv[rot1(ax)];
        end
      end
      OP_FIA: begin
        mul_a = 34'(integ_gain_x2);
        mul_b = he[ax];
      end
      OP_FIB: begin
        mul_a = 34'(tmp >>> 20);
        mul_b = 34'(sample_period);
      end
      OP_FIC: begin
        mul_a = 34'(tmp[19:0]);
        mul_b = 34'(sample_period);
      end
      OP_FP: begin
        mul_a = 34'(prop_gain_x2);
        mul_b = he[ax];
      end
      OP_HA: begin
        mul_a = 34'(g[ax] >>> 20);
        mul_b = 34'(sample_period);
      end
      OP_HB: begin
        mul_a = 34'(g[ax][19:0]);
        mul_b = 34'(sample_period);
      end
      OP_NQ: begin
        mul_a = 34'(q_c[nqt[3:2]]);
        mul_b = 34'(h[nqt[1:0]]);
      end
      OP_SQ: begin
        mul_a = 34'(nq[ax]);
        mul_b = 34'(nq[ax]);
      end
      OP_FIN: begin
        mul_a = 34'(nq[ax]);
        mul_b = 34'(zr);
      end
      OP_NA: begin
        mul_a = 34'(zr);
        mul_b = 34'(zr);
      end
      OP_NB: begin
        mul_a = 34'(m);
        mul_b = 34'(z2);
      end
      OP_NC: begin
        mul_a = 34'(zr);
        mul_b = 34'(d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // Accumulation and scaling of the registered product.
  always_comb begin
    px   = 70'(prod);
    base = (kt == 2'd0) ? (70'(q_c[ax]) <<< 30) : acc;
    case (op)
      OP_S, OP_SQ: lin = (ax == 2'd0) ? px : acc + px;
      OP_HV: begin
        if (kt == 2'd0) begin
          lin = px;
        end else if (ax == 2'd0) begin
          lin = acc - px;
        end else if (ax == 2'd1) begin
          lin = acc + px;
        end else begin
          lin = acc + px - HALF59;
        end
      end
      OP_HE:         lin = (kt == 2'd0) ? px : acc - px;
      OP_FIB, OP_HA: lin = px <<< 20;
      OP_FIC, OP_HB: lin = acc + px;
      OP_NQ:         lin = nqt[4] ? base - px : base + px;
      default:       lin = px;
    endcase
    case (op)
      OP_G:               shamt = 7'd10;
      OP_HV, OP_HE:       shamt = 7'd30;
      OP_FIA, OP_FP:      shamt = 7'd12;
      OP_FIC:             shamt = 7'd26;
      OP_HB:              shamt = 7'd25;
      OP_NQ:              shamt = 7'd32;
      OP_AH:              shamt = 7'(ex);
      OP_FIN:             shamt = 7'(ex) + 7'(QSHIFT);
      OP_NA, OP_NB:       shamt = 7'd30;
      OP_NC:              shamt = 7'd31;
      default:            shamt = 7'd0;
    endcase
    sh = lin >>> shamt;

    if (sh > ONE30) begin
      h_clamp = ONE30;
    end else if (sh < -ONE30) begin
      h_clamp = -ONE30;
    end else begin
      h_clamp = sh;
    end
    if (sh > ONE_Q) begin
      q_clamp = ONE_Q;
    end else if (sh < -ONE_Q) begin
      q_clamp = -ONE_Q;
    end else begin
      q_clamp = sh;
    end

    isum = 41'(integ[ax]) + 41'(sh);
    if (isum > I32_MAX) begin
      isat = I32_MAX;
    end else if (isum < I32_MIN) begin
      isat = I32_MIN;
    end else begin
      isat = isum;
    end

    nb_d = (sh < THREE30) ? THREE30 - sh : '0;
  end

  // Inverse square root seed from the pseudo-float of the normalised value.
  always_comb begin
    seed_m = xs[63:32];
    if (seed_m[31]) begin
      seed_bits = (32'd128 << 23) | ((seed_m - 32'h8000_0000) >> 8);
    end else begin
      seed_bits = (32'd127 << 23) | ((seed_m - 32'h4000_0000) >> 7);
    end
    seed_est  = SEED_MAGIC - (seed_bits >> 1);
    seed_frac = {1'b1, seed_est[22:0]};
    seed_z    = (seed_est[31:23] == 9'd126) ? (32'(seed_frac) << 6) : (32'(seed_frac) << 5);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      op            <= OP_G;
      ret_op        <= OP_AH;
      ax            <= 2'd0;
      kt            <= 2'd0;
      nk            <= '0;
      fb            <= 1'b0;
      m_tvalid      <= 1'b0;
      prop_gain_x2  <= PROP_GAIN_RST;
      integ_gain_x2 <= INTEG_GAIN_RST;
      sample_period <= PERIOD_RST;
      attitude[0]   <= 32'sd1 <<< QUAT_FRAC_BITS;
      attitude[1]   <= '0;
      attitude[2]   <= '0;
      attitude[3]   <= '0;
      for (int i = 0; i < 3; i++) begin
        integ[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_PROP_GAIN:  prop_gain_x2  <= cfg_data[15:0];
          REG_INTEG_GAIN: integ_gain_x2 <= cfg_data[15:0];
          REG_PERIOD:     sample_period <= cfg_data;
          default: ;
        endcase
      end

      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            for (int i = 0; i < 3; i++) begin
              rate[i]  <= s_tdata[16*i +: 16];
              accel[i] <= s_tdata[48 + 16*i +: 16];
            end
            fb    <= (s_tdata[95:48] != 48'd0);
            op    <= OP_G;
            ax    <= 2'd0;
            kt    <= 2'd0;
            state <= S_MUL;
          end
        end

        S_MUL: begin
          prod  <= mul_a * mul_b;
          state <= S_ACC;
        end

        S_ACC: begin
          acc   <= lin;
          state <= S_MUL;
          case (op)
            OP_G: begin
              g[ax] <= sh[39:0];
              if (ax != 2'd2) begin
                ax <= ax + 2'd1;
              end else begin
                ax <= 2'd0;
                op <= fb ? OP_S : OP_HA;
              end
            end
            OP_S: begin
              if (ax != 2'd2) begin
                ax <= ax + 2'd1;
              end else begin
                xs     <= lin[63:0];
                ex     <= 5'd31;
                ret_op <= OP_AH;
                state  <= S_NORM;
              end
            end
            OP_AH: begin
              ah[ax] <= sh[33:0];
              if (ax != 2'd2) begin
                ax <= ax + 2'd1;
              end else begin
                ax <= 2'd0;
                kt <= 2'd0;
                op <= OP_HV;
              end
            end
            OP_HV, OP_HE: begin
              if (kt == 2'd0) begin
                kt <= 2'd1;
              end else begin
                if (op == OP_HV) begin
                  hv[ax] <= sh[33:0];
                end else begin
                  he[ax] <= sh[33:0];
                end
                kt <= 2'd0;
                if (ax != 2'd2) begin
                  ax <= ax + 2'd1;
                end else begin
                  ax <= 2'd0;
                  op <= (op == OP_HV) ? OP_HE : OP_FIA;
                end
              end
            end
            OP_FIA: begin
              tmp <= sh[39:0];
              if (integ_gain_x2 == 16'd0) begin
                // A zero integral gain clears the stored term.
                integ[ax] <= '0;
                op        <= OP_FP;
              end else begin
                op <= OP_FIB;
              end
            end
            OP_FIB: op <= OP_FIC;
            OP_FIC: begin
              integ[ax] <= isat[31:0];
              g[ax]     <= g[ax] + (40'(isat) <<< 2);
              op        <= OP_FP;
            end
            OP_FP: begin
              g[ax] <= g[ax] + sh[39:0];
              if (ax != 2'd2) begin
                ax <= ax + 2'd1;
                op <= OP_FIA;
              end else begin
                ax <= 2'd0;
                op <= OP_HA;
              end
            end
            OP_HA: op <= OP_HB;
            OP_HB: begin
              h[ax] <= h_clamp[31:0];
              if (ax != 2'd2) begin
                ax <= ax + 2'd1;
                op <= OP_HA;
              end else begin
                ax <= 2'd0;
                kt <= 2'd0;
                op <= OP_NQ;
              end
            end
            OP_NQ: begin
              if (kt != 2'd2) begin
                kt <= kt + 2'd1;
              end else begin
                nq[ax] <= sh[32:0];
                kt     <= 2'd0;
                if (ax != 2'd3) begin
                  ax <= ax + 2'd1;
                end else begin
                  ax <= 2'd0;
                  op <= OP_SQ;
                end
              end
            end
            OP_SQ: begin
              if (ax != 2'd3) begin
                ax <= ax + 2'd1;
              end else if (lin[63:0] == 64'd0) begin
                // Degenerate quaternion: fall back to the identity.
                attitude[0] <= 32'sd1 <<< QUAT_FRAC_BITS;
                attitude[1] <= '0;
                attitude[2] <= '0;
                attitude[3] <= '0;
                state       <= S_DONE;
              end else begin
                xs     <= lin[63:0];
                ex     <= 5'd31;
                ret_op <= OP_FIN;
                state  <= S_NORM;
              end
            end
            OP_FIN: begin
              attitude[ax] <= q_clamp[31:0];
              if (ax != 2'd3) begin
                ax <= ax + 2'd1;
              end else begin
                state <= S_DONE;
              end
            end
            OP_NA: begin
              z2 <= sh[32:0];
              op <= OP_NB;
            end
            OP_NB: begin
              d  <= nb_d[31:0];
              op <= OP_NC;
            end
            OP_NC: begin
              zr <= sh[31:0];
              if (nk == NK_W'(NEWTON_STEPS - 1)) begin
                nk <= '0;
                ax <= 2'd0;
                kt <= 2'd0;
                op <= ret_op;
              end else begin
                nk <= nk + NK_W'(1);
                op <= OP_NA;
              end
            end
            default: state <= S_DONE;
          endcase
        end

        S_NORM: begin
          // Bring the leading bit pair to the top, a byte at a time while
          // possible, then a pair at a time.
          if ((xs[63:56] == 8'd0) && (ex >= 5'd4)) begin
            xs <= xs << 8;
            ex <= ex - 5'd4;
          end else if (xs[63:62] == 2'd0) begin
            xs <= xs << 2;
            ex <= ex - 5'd1;
          end else begin
            m     <= seed_m;
            zr    <= seed_z;
            nk    <= '0;
            op    <= OP_NA;
            state <= S_MUL;
          end
        end

        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {attitude[3], attitude[2], attitude[1], attitude[0]};
            m_tuser  <= fb;
            state    <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_imu_quaternion_attitude_filter.sv =====
// Testbench for the IMU quaternion attitude filter: drives IMU sample words,
// predicts each updated quaternion in a scoreboard class and compares it.
// Depends on imuqaf_pkg and the imu_quaternion_attitude_filter RTL.
`timescale 1ns / 1ps

module tb_imu_quaternion_attitude_filter;
  import imuqaf_pkg::*;

  localparam int QFB = QUAT_FRAC_BITS_DEF;
  localparam int NSTEPS = NEWTON_STEPS_DEF;
  localparam longint ONE_Q30 = 64'sd1 << 30;
  localparam int RANDOM_SAMPLES = 1830;
  localparam longint CYCLE_LIMIT = 64'd3_000_000;
  // An index past the end of the register list.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  typedef struct packed {
    logic signed [15:0] accel_z, accel_y, accel_x, rate_z, rate_y, rate_x;
  } sample_t;

  typedef struct {
    logic signed [31:0] quat[4];
    logic feedback_used;
  } attitude_word_t;

  function automatic longint sar(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Inverse square root: 1/sqrt(s) ~= z * 2^-(30+e), z in Q30.
  function automatic longint unsigned rsqrt(longint unsigned s, output int e);
    int p;
    int ex;
    longint unsigned m, z, bits, est, frac, z2, t, d;
    if (s == 0) begin
      e = 0;
      return 0;
    end
    p = 63;
    while (s[p] == 1'b0) p--;
    ex = p >> 1;
    e = ex;
    if (2 * ex <= 30) m = s << (30 - 2 * ex);
    else m = s >> (2 * ex - 30);
    if (m < (64'd1 << 31)) bits = (64'd127 << 23) | ((m - (64'd1 << 30)) >> 7);
    else bits = (64'd128 << 23) | ((m - (64'd1 << 31)) >> 8);
    est = {32'd0, SEED_MAGIC} - (bits >> 1);
    frac = (est & 64'h7FFFFF) | 64'h800000;
    z = ((est >> 23) == 126) ? (frac << 6) : (frac << 5);
    for (int k = 0; k < NSTEPS; k++) begin
      z2 = (z * z) >> 30;
      t = (m * z2) >> 30;
      d = t < (64'd3 << 30) ? (64'd3 << 30) - t : 0;
      z = (z * d) >> 31;
    end
    return z;
  endfunction

  class attitude_scoreboard;
    logic signed [31:0] attitude[4];
    logic signed [31:0] integral[3];
    logic [15:0] prop_gain;
    logic [15:0] integ_gain;
    logic [23:0] period;
    attitude_word_t pending[$];
    int mismatches;

    function void init();
      attitude[0] = 32'sd1 << QFB;
      for (int i = 1; i < 4; i++) attitude[i] = '0;
      for (int i = 0; i < 3; i++) integral[i] = '0;
      prop_gain = PROP_GAIN_RST;
      integ_gain = INTEG_GAIN_RST;
      period = PERIOD_RST;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
      case (idx)
        REG_PROP_GAIN: prop_gain = val[15:0];
        REG_INTEG_GAIN: integ_gain = val[15:0];
        REG_PERIOD: period = val;
        default: ;
      endcase
    endfunction

    function void note_sample(sample_t smp);
      longint g[3], a[3], q[4], h[3], n[4], ah[3], hv[3], he[3];
      longint dt, one_q, inc, v;
      longint unsigned s, z;
      int e;
      logic fb;
      attitude_word_t w;
      dt = longint'(period);
      one_q = 64'sd1 << QFB;
      g[0] = sar(longint'(smp.rate_x) * RATE_TO_RAD_Q40, 10);
      g[1] = sar(longint'(smp.rate_y) * RATE_TO_RAD_Q40, 10);
      g[2] = sar(longint'(smp.rate_z) * RATE_TO_RAD_Q40, 10);
      a[0] = smp.accel_x;
      a[1] = smp.accel_y;
      a[2] = smp.accel_z;
      for (int i = 0; i < 4; i++) q[i] = longint'(attitude[i]) <<< (30 - QFB);
      fb = (a[0] != 0) || (a[1] != 0) || (a[2] != 0);
      if (fb) begin
        s = a[0] * a[0] + a[1] * a[1] + a[2] * a[2];
        z = rsqrt(s, e);
        for (int i = 0; i < 3; i++) ah[i] = sar(a[i] * longint'(z), e);
        hv[0] = sar(q[1] * q[3] - q[0] * q[2], 30);
        hv[1] = sar(q[0] * q[1] + q[2] * q[3], 30);
        hv[2] = sar(q[0] * q[0] + q[3] * q[3] - (64'sd1 << 59), 30);
        he[0] = sar(ah[1] * hv[2] - ah[2] * hv[1], 30);
        he[1] = sar(ah[2] * hv[0] - ah[0] * hv[2], 30);
        he[2] = sar(ah[0] * hv[1] - ah[1] * hv[0], 30);
        for (int i = 0; i < 3; i++) begin
          if (integ_gain != 0) begin
            inc = sar(sar(longint'(integ_gain) * he[i], 12) * dt, 26);
            v = clip(longint'(integral[i]) + inc, -64'sd2147483648, 64'sd2147483647);
            integral[i] = 32'(v);
            g[i] += v * 4;
          end else begin
            integral[i] = '0;
          end
          g[i] += sar(longint'(prop_gain) * he[i], 12);
        end
      end
      for (int i = 0; i < 3; i++) h[i] = clip(sar(g[i] * dt, 25), -ONE_Q30, ONE_Q30);
      n[0] = q[0] * ONE_Q30 - q[1] * h[0] - q[2] * h[1] - q[3] * h[2];
      n[1] = q[1] * ONE_Q30 + q[0] * h[0] + q[2] * h[2] - q[3] * h[1];
      n[2] = q[2] * ONE_Q30 + q[0] * h[1] - q[1] * h[2] + q[3] * h[0];
      n[3] = q[3] * ONE_Q30 + q[0] * h[2] + q[1] * h[1] - q[2] * h[0];
      s = 0;
      for (int i = 0; i < 4; i++) begin
        n[i] = sar(n[i], 32);
        s += n[i] * n[i];
      end
      if (s == 0) begin
        attitude[0] = 32'(one_q);
        for (int i = 1; i < 4; i++) attitude[i] = '0;
      end else begin
        z = rsqrt(s, e);
        for (int i = 0; i < 4; i++) begin
          v = sar(sar(n[i] * longint'(z), e), 30 - QFB);
          attitude[i] = 32'(clip(v, -one_q, one_q));
        end
      end
      for (int i = 0; i < 4; i++) w.quat[i] = attitude[i];
      w.feedback_used = fb;
      pending.push_back(w);
    endfunction

    function void check_word(logic [127:0] data, logic user);
      attitude_word_t exp_w;
      logic bad;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected output word: %h %b", data, user);
        return;
      end
      exp_w = pending.pop_front();
      bad = (user != exp_w.feedback_used);
      for (int i = 0; i < 4; i++) if (data[32*i +: 32] != exp_w.quat[i]) bad = 1;
      if (bad) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Mismatch: expected q=%0d,%0d,%0d,%0d fb=%b got q=%0d,%0d,%0d,%0d fb=%b",
                   exp_w.quat[0], exp_w.quat[1], exp_w.quat[2], exp_w.quat[3],
                   exp_w.feedback_used, $signed(data[31:0]), $signed(data[63:32]),
                   $signed(data[95:64]), $signed(data[127:96]), user);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [95:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [127:0] m_tdata;
  logic m_tuser;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  attitude_scoreboard board;
  longint cycle_count;
  logic calm;        // no idling on either side
  logic hold_output; // long receiver stall

  imu_quaternion_attitude_filter DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // Receiver: random stalls, checks each word accepted.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_word(m_tdata, m_tuser);
    if (rst || hold_output) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= 22);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // The write strobe drops for one cycle after each write.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    board.write_reg(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Offers one word and holds it until accepted; the valid stays high
  // afterwards so that the next word can follow at once.
  task automatic send_sample(sample_t smp);
    while (!calm && $urandom_range(99) < 22) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= smp;
    do @(posedge clk); while (!s_tready);
    board.note_sample(smp);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_field();
    case ($urandom_range(7))
      0: return 16'sh8000;
      1: return 16'sh7FFF;
      2: return '0;
      3: return 16'($urandom_range(64) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t smp;
    smp.rate_x = rand_field();
    smp.rate_y = rand_field();
    smp.rate_z = rand_field();
    if ($urandom_range(9) == 0) begin
      smp.accel_x = '0;
      smp.accel_y = '0;
      smp.accel_z = '0;
    end else begin
      smp.accel_x = rand_field();
      smp.accel_y = rand_field();
      smp.accel_z = rand_field();
    end
    // Mostly a realistic, slowly turning sensor
    if ($urandom_range(3) != 0) begin
      smp.rate_x = 16'($urandom_range(1600) - 800);
      smp.rate_y = 16'($urandom_range(1600) - 800);
      smp.rate_z = 16'($urandom_range(1600) - 800);
    end
    return smp;
  endfunction

  function automatic sample_t make_sample(int rx, int ry, int rz, int ax, int ay, int az);
    sample_t smp;
    smp.rate_x = 16'(rx);
    smp.rate_y = 16'(ry);
    smp.rate_z = 16'(rz);
    smp.accel_x = 16'(ax);
    smp.accel_y = 16'(ay);
    smp.accel_z = 16'(az);
    return smp;
  endfunction

  initial begin
    int phase_len;
    board = new();
    board.init();
    cycle_count = 0;
    calm = 1'b0;
    hold_output = 1'b0;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_PROP_GAIN;
    cfg_data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, zero accelerometer, huge rotation steps.
    send_sample(make_sample(0, 0, 0, 0, 0, 1000));
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 32767));
    send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, -32768));
    send_sample(make_sample(100, -200, 300, 0, 0, 0));
    send_sample(make_sample(-32768, 32767, 0, 1, 0, 0));
    send_sample(make_sample(0, 0, 0, -32768, 0, 0));
    send_sample(make_sample(5, 5, 5, 0, -1, 0));
    drain();
    // Maximum gains and period drive the integral into saturation.
    write_reg(REG_PROP_GAIN, 24'hFFFF);
    write_reg(REG_INTEG_GAIN, 24'hFFFF);
    write_reg(REG_PERIOD, 24'hFFFFFF);
    for (int i = 0; i < 6; i++)
      send_sample(make_sample(32767, -32768, 32767, 32767, -32768, 1));
    drain();
    // Zero integral gain clears the integral; smallest period.
    write_reg(REG_INTEG_GAIN, 24'd0);
    write_reg(REG_PERIOD, 24'd1);
    write_reg(REG_PROP_GAIN, 24'd0);
    write_reg(REG_SPARE, 24'h123456);
    send_sample(make_sample(1000, 1000, 1000, 500, 0, 0));
    send_sample(make_sample(0, 0, 0, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin
          write_reg(REG_PROP_GAIN, 24'(PROP_GAIN_RST));
          write_reg(REG_INTEG_GAIN, 24'(INTEG_GAIN_RST));
          write_reg(REG_PERIOD, PERIOD_RST);
        end
        1: begin
          write_reg(REG_PROP_GAIN, 24'hFFFF);
          write_reg(REG_INTEG_GAIN, 24'd0);
          write_reg(REG_PERIOD, 24'hFFFFFF);
        end
        default: begin
          write_reg(REG_PROP_GAIN, 24'($urandom_range(65535)));
          write_reg(REG_INTEG_GAIN,
                    24'($urandom_range(3) == 0 ? 0 : $urandom_range(65535)));
          write_reg(REG_PERIOD, 24'($urandom_range(3) == 0 ? $urandom_range(16777215, 1)
                                                             : $urandom_range(200000, 1)));
        end
      endcase
      phase_len = RANDOM_SAMPLES / 6;
      for (int i = 0; i < phase_len; i++) begin
        if (ph == 2 && i == 40) begin
          // Long receiver stall while the sender keeps offering words.
          fork
            begin
              hold_output = 1'b1;
              repeat (2000) @(posedge clk);
              hold_output = 1'b0;
            end
          join_none
        end
        calm = (ph == 3 && i >= 50 && i < 150);
        send_sample(rand_sample());
      end
      calm = 1'b0;
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hw/rtl/imuqaf_pkg.sv
hw/rtl/imu_quaternion_attitude_filter.sv
tb/sv/tb_imu_quaternion_attitude_filter.sv
